@@ hw/rtl/spi_se_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine package
// Shared types, codes and widths of the SPI endpoint byte shifter.
// ----------------------------------------------------------------------------
package spi_se_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CountW   = 4;
  localparam int unsigned RegIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  localparam logic [CountW-1:0] LastEdge = 4'd15;

  typedef enum logic [ActionW-1:0] {
    ActClock  = 2'd0,
    ActLoad   = 2'd1,
    ActEnable = 2'd2
  } action_e;

  typedef enum logic [RegIdxW-1:0] {
    RegSerialMode = 1'd0,
    RegMsbFirst   = 1'd1
  } reg_idx_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               clock_level;
    logic               data_in;
    logic [ByteW-1:0]   tx_byte;
    logic               enable;
  } in_item_t;

  typedef struct packed {
    logic               data_out;
    logic               frame_done;
    logic [ByteW-1:0]   shift_value;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [RegIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

@@ hw/rtl/spi_se_if.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine channels
// Valid/ready channels for input events and result transfers.
// ----------------------------------------------------------------------------
interface spi_se_in_if;
  logic                                valid;
  logic                                ready;
  logic [spi_se_pkg::ActionW-1:0]      action;
  logic                                clock_level;
  logic                                data_in;
  logic [spi_se_pkg::ByteW-1:0]        tx_byte;
  logic                                enable;

  modport source (output valid, action, clock_level, data_in, tx_byte, enable,
                  input ready);
  modport sink   (input valid, action, clock_level, data_in, tx_byte, enable,
                  output ready);
endinterface

interface spi_se_out_if;
  logic                                valid;
  logic                                ready;
  logic                                data_out;
  logic                                frame_done;
  logic [spi_se_pkg::ByteW-1:0]        shift_value;

  modport source (output valid, data_out, frame_done, shift_value, input ready);
  modport sink   (input valid, data_out, frame_done, shift_value, output ready);
endinterface

@@ hw/rtl/spi_se_in_stage.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine input stage
// Registers one input event and hands it on when the engine advances.
// ----------------------------------------------------------------------------
module spi_se_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  spi_se_pkg::in_item_t in_item_i,
  output logic                 in_ready_o,
  input  logic                 advance_i,
  output spi_se_pkg::stage_t   stage_o
);

  logic                 valid_q, valid_d;
  spi_se_pkg::in_item_t item_q;
  logic                 load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

@@ hw/rtl/spi_se_engine.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine datapath
// Endpoint state, edge decode, shifter update and result register.
// ----------------------------------------------------------------------------
module spi_se_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spi_se_pkg::cfg_wr_t   cfg_i,
  input  spi_se_pkg::stage_t    stage_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output spi_se_pkg::out_item_t out_item_o
);

  logic [spi_se_pkg::ModeW-1:0]  mode_q;
  logic                          msb_q;
  logic [spi_se_pkg::ByteW-1:0]  shifter_q, shifter_d;
  logic [spi_se_pkg::CountW-1:0] count_q, count_d;
  logic                          en_q, en_d;
  logic                          clk_seen_q, clk_seen_d;
  logic                          lvl_q, lvl_d;
  logic                          done_d;
  logic                          out_valid_q;
  spi_se_pkg::out_item_t         out_q;

  logic                          cpol, cpha, eff, drive_bit, fire;
  logic [spi_se_pkg::ByteW-1:0]  shifted;
  spi_se_pkg::in_item_t          it;

  assign it        = stage_i.item;
  assign cpol      = mode_q[1];
  assign cpha      = mode_q[0];
  assign eff       = it.clock_level ^ cpol;
  assign drive_bit = msb_q ? shifter_q[spi_se_pkg::ByteW-1] : shifter_q[0];
  assign shifted   = msb_q ? {shifter_q[spi_se_pkg::ByteW-2:0], it.data_in}
                           : {it.data_in, shifter_q[spi_se_pkg::ByteW-1:1]};

  assign advance_o = !out_valid_q || out_ready_i;
  assign fire      = stage_i.valid && advance_o;

  always_comb begin
    shifter_d  = shifter_q;
    count_d    = count_q;
    en_d       = en_q;
    clk_seen_d = clk_seen_q;
    lvl_d      = lvl_q;
    done_d     = 1'b0;
    case (it.action)
      spi_se_pkg::ActClock: begin
        if (it.clock_level != clk_seen_q) begin
          clk_seen_d = it.clock_level;
          if (en_q) begin
            if (cpha) begin
              if (eff) lvl_d = drive_bit;
              else     shifter_d = shifted;
            end else begin
              if (eff) shifter_d = shifted;
              else if (count_q != spi_se_pkg::LastEdge) lvl_d = drive_bit;
            end
            if (count_q != spi_se_pkg::LastEdge) begin
              count_d = count_q + 1'b1;
            end else begin
              count_d = '0;
              done_d  = 1'b1;
            end
          end
        end
      end
      spi_se_pkg::ActLoad: begin
        shifter_d = it.tx_byte;
        lvl_d     = msb_q ? it.tx_byte[spi_se_pkg::ByteW-1] : it.tx_byte[0];
      end
      spi_se_pkg::ActEnable: begin
        if (it.enable && !en_q) count_d = '0;
        en_d = it.enable;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      msb_q       <= 1'b1;
      shifter_q   <= '0;
      count_q     <= '0;
      en_q        <= 1'b0;
      clk_seen_q  <= 1'b0;
      lvl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        shifter_q  <= shifter_d;
        count_q    <= count_d;
        en_q       <= en_d;
        clk_seen_q <= clk_seen_d;
        lvl_q      <= lvl_d;
      end else if (cfg_i.we && cfg_i.idx == spi_se_pkg::RegMsbFirst) begin
        msb_q <= cfg_i.data[0];
        lvl_q <= cfg_i.data[0] ? shifter_q[spi_se_pkg::ByteW-1] : shifter_q[0];
      end else if (cfg_i.we && cfg_i.idx == spi_se_pkg::RegSerialMode) begin
        mode_q <= cfg_i.data;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.data_out    <= lvl_d;
      out_q.frame_done  <= done_d;
      out_q.shift_value <= shifter_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/spi_endpoint_shift_engine_core.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine core
// Event-driven SPI endpoint byte shifter for modes 0 to 3.
// ----------------------------------------------------------------------------
// Each input transfer is one event (clock line level, byte load or enable
// change) and gives exactly one result transfer, via the input register and
// then the result register. A new event is taken every cycle while the result
// side keeps up: the edge decode and shifter update write the result register
// in one step. Configuration writes are lost when an event moves on in the
// same cycle; the user must make them while no event is in flight, which the
// block itself does not enforce.
module spi_endpoint_shift_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spi_se_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [spi_se_pkg::CfgDataW-1:0]    cfg_data_i,
  spi_se_in_if.sink                          in_i,
  spi_se_out_if.source                       out_o
);

  spi_se_pkg::in_item_t  in_item;
  spi_se_pkg::stage_t    stage;
  spi_se_pkg::cfg_wr_t   cfg;
  spi_se_pkg::out_item_t out_item;
  logic                  advance;

  assign in_item.action      = in_i.action;
  assign in_item.clock_level = in_i.clock_level;
  assign in_item.data_in     = in_i.data_in;
  assign in_item.tx_byte     = in_i.tx_byte;
  assign in_item.enable      = in_i.enable;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  spi_se_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_i.ready),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  spi_se_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.data_out    = out_item.data_out;
  assign out_o.frame_done  = out_item.frame_done;
  assign out_o.shift_value = out_item.shift_value;

endmodule

@@ hw/rtl/spi_se_checker.sv @@
// ----------------------------------------------------------------------------
// SPI endpoint shift engine checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module spi_se_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          data_out_i,
  input logic                          frame_done_i,
  input logic [spi_se_pkg::ByteW-1:0]  shift_value_i
);

  logic [spi_se_pkg::ByteW+1:0] out_bus;
  assign out_bus = {data_out_i, frame_done_i, shift_value_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bus))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");

  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && frame_done_i |=> !(out_valid_i && frame_done_i))
    else $error("frame done on consecutive transfers");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i && in_ready_i)
    else $error("channel active in reset");

endmodule

bind spi_endpoint_shift_engine_core spi_se_checker u_spi_se_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .data_out_i    (out_o.data_out),
  .frame_done_i  (out_o.frame_done),
  .shift_value_i (out_o.shift_value)
);

@@ bench/spi_se_shift_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI endpoint shift engine checker
// Watches the configuration port and both channels, keeps a bit-true copy of
// the shifter state, predicts the result of each accepted event and compares
// every result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module spi_se_shift_checker
  import spi_se_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  spi_se_in_if                ev_ch,
  spi_se_out_if               res_ch,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         frames_o
);

  logic [ModeW-1:0]  serial_mode;
  logic              msb_first;
  logic [ByteW-1:0]  shreg;
  logic [CountW-1:0] edge_cnt;
  logic              ep_enabled;
  logic              clk_seen;
  logic              out_level;

  out_item_t   expected_results[$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned frame_count;

  function automatic void drive_bit();
    out_level = msb_first ? shreg[ByteW-1] : shreg[0];
  endfunction

  function automatic void shift_bit(input logic din);
    if (msb_first) begin
      shreg = {shreg[ByteW-2:0], din};
    end else begin
      shreg = {din, shreg[ByteW-1:1]};
    end
  endfunction

  function automatic out_item_t predict_event(input in_item_t ev);
    out_item_t res;
    logic      lvl;
    res.frame_done = 1'b0;
    case (ev.action)
      ActClock: begin
        if (ev.clock_level != clk_seen) begin
          clk_seen = ev.clock_level;
          if (ep_enabled) begin
            lvl = ev.clock_level ^ serial_mode[1];
            if (serial_mode[0]) begin
              if (lvl) drive_bit();
              else shift_bit(ev.data_in);
            end else begin
              if (lvl) shift_bit(ev.data_in);
              else if (edge_cnt != LastEdge) drive_bit();
            end
            if (edge_cnt == LastEdge) begin
              edge_cnt       = '0;
              res.frame_done = 1'b1;
            end else begin
              edge_cnt = edge_cnt + 1'b1;
            end
          end
        end
      end
      ActLoad: begin
        shreg = ev.tx_byte;
        drive_bit();
      end
      ActEnable: begin
        if (ev.enable && !ep_enabled) edge_cnt = '0;
        ep_enabled = ev.enable;
      end
      default: ;
    endcase
    res.data_out    = out_level;
    res.shift_value = shreg;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t  ev;
    out_item_t exp_res;
    if (!rst_ni) begin
      serial_mode = '0;
      msb_first   = 1'b1;
      shreg       = '0;
      edge_cnt    = '0;
      ep_enabled  = 1'b0;
      clk_seen    = 1'b0;
      out_level   = 1'b0;
      expected_results.delete();
      mismatch_count = 0;
      result_count   = 0;
      frame_count    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSerialMode: serial_mode = cfg_data_i[ModeW-1:0];
          RegMsbFirst: begin
            msb_first = cfg_data_i[0];
            drive_bit();
          end
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transfer, got data_out %0b frame_done %0b shift %02h",
                   $time, res_ch.data_out, res_ch.frame_done, res_ch.shift_value);
        end else begin
          exp_res = expected_results.pop_front();
          if (res_ch.data_out !== exp_res.data_out) begin
            mismatch_count++;
            $display("%0t: data_out mismatch, expected %0b, got %0b",
                     $time, exp_res.data_out, res_ch.data_out);
          end
          if (res_ch.frame_done !== exp_res.frame_done) begin
            mismatch_count++;
            $display("%0t: frame_done mismatch, expected %0b, got %0b",
                     $time, exp_res.frame_done, res_ch.frame_done);
          end
          if (res_ch.shift_value !== exp_res.shift_value) begin
            mismatch_count++;
            $display("%0t: shift_value mismatch, expected %02h, got %02h",
                     $time, exp_res.shift_value, res_ch.shift_value);
          end
        end
      end
      if (ev_ch.valid && ev_ch.ready) begin
        ev.action      = ev_ch.action;
        ev.clock_level = ev_ch.clock_level;
        ev.data_in     = ev_ch.data_in;
        ev.tx_byte     = ev_ch.tx_byte;
        ev.enable      = ev_ch.enable;
        exp_res = predict_event(ev);
        if (exp_res.frame_done) frame_count++;
        expected_results.push_back(exp_res);
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_results.size();
    results_o    <= result_count;
    frames_o     <= frame_count;
  end

endmodule

@@ bench/tb_spi_endpoint_shift_engine_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI endpoint shift engine testbench
// Drives event transfers into the shift engine: a directed opening, then
// mostly well-formed byte frames with random data under every mode and bit
// order, mixed with stray events. Both channels idle in random bursts; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_spi_endpoint_shift_engine_core;
  import spi_se_pkg::*;

  localparam logic [ActionW-1:0] ActUnused  = 2'd3;
  localparam int unsigned        PhaseItems = 52;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  spi_se_in_if  ev_ch ();
  spi_se_out_if res_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned frames;

  logic [ModeW-1:0] cur_mode;
  logic             line_level;
  bit               idle_on;
  bit               stall_on;
  int unsigned      stall_left = 0;
  int unsigned      events_sent = 0;

  spi_endpoint_shift_engine_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (ev_ch),
    .out_o      (res_ch)
  );

  spi_se_shift_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .ev_ch        (ev_ch),
    .res_ch       (res_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .frames_o     (frames)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic in_item_t make_event(input logic [ActionW-1:0] action,
                                          input logic lvl, input logic din,
                                          input logic [ByteW-1:0] tx,
                                          input logic en);
    in_item_t ev;
    ev.action      = action;
    ev.clock_level = lvl;
    ev.data_in     = din;
    ev.tx_byte     = tx;
    ev.enable      = en;
    return ev;
  endfunction

  task automatic send_event(input in_item_t ev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    ev_ch.valid       <= 1'b1;
    ev_ch.action      <= ev.action;
    ev_ch.clock_level <= ev.clock_level;
    ev_ch.data_in     <= ev.data_in;
    ev_ch.tx_byte     <= ev.tx_byte;
    ev_ch.enable      <= ev.enable;
    do @(posedge clk_i); while (!ev_ch.ready);
    events_sent++;
    if (ev.action == ActClock) line_level = ev.clock_level;
  endtask

  task automatic send_clock(input logic lvl);
    send_event(make_event(ActClock, lvl, 1'($urandom), ByteW'($urandom), 1'($urandom)));
  endtask

  task automatic send_noise();
    send_event(make_event(ActionW'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                          ByteW'($urandom), 1'($urandom)));
  endtask

  // mostly disable first, then park the clock at its idle level, enable, load,
  // then clock the frame out with rare stray events; a few frames are cut short
  task automatic send_frame();
    int unsigned n_edges;
    n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 16;
    if ($urandom_range(0, 3) != 0) begin
      send_event(make_event(ActEnable, 1'($urandom), 1'($urandom), ByteW'($urandom), 1'b0));
    end
    send_clock(cur_mode[1]);
    send_event(make_event(ActEnable, 1'($urandom), 1'($urandom), ByteW'($urandom), 1'b1));
    send_event(make_event(ActLoad, 1'($urandom), 1'($urandom), ByteW'($urandom),
                          1'($urandom)));
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      send_clock(~line_level);
    end
  endtask

  // drop valid and wait for every outstanding result, with a limit
  task automatic drain();
    int unsigned waited;
    ev_ch.valid <= 1'b0;
    @(posedge clk_i);
    for (waited = 0; pending != 0 && waited < 2000; waited++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_start;
    bit          last_phase;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= RegSerialMode;
    cfg_data_i        <= '0;
    ev_ch.valid       <= 1'b0;
    ev_ch.action      <= ActClock;
    ev_ch.clock_level <= 1'b0;
    ev_ch.data_in     <= 1'b0;
    ev_ch.tx_byte     <= '0;
    ev_ch.enable      <= 1'b0;
    cur_mode   = '0;
    line_level = 1'b0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening: unchanged level, disabled edges, stray code, extreme bytes,
    // repeated enable, then one full frame in the reset mode
    send_event(make_event(ActClock, 1'b0, 1'b1, 8'hFF, 1'b1));
    send_event(make_event(ActClock, 1'b1, 1'b1, 8'h00, 1'b0));
    send_event(make_event(ActClock, 1'b0, 1'b0, 8'hFF, 1'b1));
    send_event(make_event(ActUnused, 1'b1, 1'b1, 8'hFF, 1'b1));
    send_event(make_event(ActLoad, 1'b1, 1'b1, 8'h00, 1'b1));
    send_event(make_event(ActEnable, 1'b1, 1'b1, 8'hFF, 1'b1));
    send_event(make_event(ActEnable, 1'b0, 1'b0, 8'h00, 1'b1));
    send_event(make_event(ActLoad, 1'b0, 1'b0, 8'hFF, 1'b0));
    for (int i = 0; i < 16; i++) begin
      send_event(make_event(ActClock, ~line_level, 1'(i), ByteW'($urandom), 1'($urandom)));
    end
    send_event(make_event(ActEnable, 1'b1, 1'b1, 8'hFF, 1'b0));

    for (int m = 0; m < 4; m++) begin
      for (int b = 1; b >= 0; b--) begin
        drain();
        cur_mode = ModeW'(m);
        cfg_write(RegSerialMode, CfgDataW'(m));
        cfg_write(RegMsbFirst, {1'($urandom), 1'(b)});
        last_phase  = (m == 3 && b == 0);
        phase_start = events_sent;
        while (events_sent - phase_start < PhaseItems) begin
          idle_on  = !last_phase && $urandom_range(0, 3) != 0;
          stall_on = !last_phase && $urandom_range(0, 3) != 0;
          if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_noise();
          end else begin
            send_frame();
          end
        end
      end
    end

    drain();
    $display("Run covered %0d events and %0d results, %0d completed frames,",
             events_sent, results, frames);
    $display("across all four serial modes in both bit orders, with %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
